### hdl/sush_pkg.sv
`timescale 1ns / 1ps

package sush_pkg;

    // Request codes on the input channel
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Result kinds on the output channel
    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    // Configuration register indexes
    localparam logic CFG_TIMEOUT  = 1'b0;
    localparam logic CFG_MAX_ATT  = 1'b1;

    localparam logic [23:0] TIMEOUT_RESET = 24'd3;
    localparam logic [3:0]  MAX_ATT_RESET = 4'd3;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [2:0] FRAME_LAST = 3'd4;
    localparam logic [7:0] FLAG_BYTE  = 8'h7E;

    // Work handed from the front end to the back end
    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_SET  = 2'd0;
    localparam cmd_t CMD_OK   = 2'd1;
    localparam cmd_t CMD_FAIL = 2'd2;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_req_t;

    // SET frame: flag, address, control, BCC, flag
    function automatic logic [7:0] set_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h7E;
            3'd1:    b = 8'h03;
            3'd2:    b = 8'h03;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h7E;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Expected UA frame
    function automatic logic [7:0] ua_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h7E;
            3'd1:    b = 8'h01;
            3'd2:    b = 8'h07;
            3'd3:    b = 8'h06;
            3'd4:    b = 8'h7E;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### hdl/sush_front.sv
`timescale 1ns / 1ps

module sush_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_accept,
    input  logic [1:0]          req_type,
    input  logic [7:0]          rx_byte,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [23:0]         cfg_data,
    output sush_pkg::q_req_t    q_push
);

    localparam logic PH_IDLE = 1'b0;
    localparam logic PH_WAIT = 1'b1;

    logic        phase_reg,    phase_next;
    logic [3:0]  attempts_reg, attempts_next;
    logic [23:0] tick_reg,     tick_next;
    logic [2:0]  match_reg,    match_next;
    logic [23:0] timeout_reg;
    logic [3:0]  max_att_reg;

    logic [23:0] limit;
    logic [3:0]  max_att;
    logic [23:0] tick_inc;

    assign limit    = (timeout_reg == 24'd0) ? 24'd1 : timeout_reg;
    assign max_att  = (max_att_reg == 4'd0) ? 4'd1 : max_att_reg;
    assign tick_inc = tick_reg + 24'd1;

    always_comb begin
        phase_next    = phase_reg;
        attempts_next = attempts_reg;
        tick_next     = tick_reg;
        match_next    = match_reg;
        q_push.valid  = 1'b0;
        q_push.cmd    = sush_pkg::CMD_SET;
        if (s_accept) begin
            unique case (req_type)
                sush_pkg::REQ_START: begin
                    if (phase_reg == PH_IDLE) begin
                        attempts_next = 4'd1;
                        tick_next     = '0;
                        match_next    = '0;
                        phase_next    = PH_WAIT;
                        q_push.valid  = 1'b1;
                        q_push.cmd    = sush_pkg::CMD_SET;
                    end
                end
                sush_pkg::REQ_BYTE: begin
                    if (phase_reg == PH_WAIT) begin
                        if (rx_byte == sush_pkg::ua_byte(match_reg)) begin
                            if (match_reg == sush_pkg::FRAME_LAST) begin
                                match_next   = '0;
                                tick_next    = '0;
                                phase_next   = PH_IDLE;
                                q_push.valid = 1'b1;
                                q_push.cmd   = sush_pkg::CMD_OK;
                            end else begin
                                match_next = match_reg + 3'd1;
                            end
                        end else begin
                            // a stray flag may open a new frame
                            match_next = (rx_byte == sush_pkg::FLAG_BYTE) ? 3'd1 : 3'd0;
                        end
                    end
                end
                sush_pkg::REQ_TICK: begin
                    if (phase_reg == PH_WAIT) begin
                        if (tick_inc < limit) begin
                            tick_next = tick_inc;
                        end else begin
                            tick_next    = '0;
                            match_next   = '0;
                            q_push.valid = 1'b1;
                            if (attempts_reg >= max_att) begin
                                phase_next = PH_IDLE;
                                q_push.cmd = sush_pkg::CMD_FAIL;
                            end else begin
                                attempts_next = attempts_reg + 4'd1;
                                q_push.cmd    = sush_pkg::CMD_SET;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            attempts_reg <= '0;
            tick_reg     <= '0;
            match_reg    <= '0;
            timeout_reg  <= sush_pkg::TIMEOUT_RESET;
            max_att_reg  <= sush_pkg::MAX_ATT_RESET;
        end else begin
            phase_reg    <= phase_next;
            attempts_reg <= attempts_next;
            tick_reg     <= tick_next;
            match_reg    <= match_next;
            if (cfg_write) begin
                if (cfg_index == sush_pkg::CFG_TIMEOUT) begin
                    timeout_reg <= cfg_data;
                end else begin
                    max_att_reg <= cfg_data[3:0];
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_push_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push.valid |-> s_accept)
        else $error("front pushed work without an accepted request");

    a_match_range: assert property (@(posedge aclk) disable iff (!aresetn)
        match_reg <= sush_pkg::FRAME_LAST)
        else $error("UA match position out of range");

    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push.valid && q_push.cmd != sush_pkg::CMD_SET) |=> phase_reg == PH_IDLE)
        else $error("handshake still waiting after success or failure");

    a_set_goes_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push.valid && q_push.cmd == sush_pkg::CMD_SET)
            |=> (phase_reg == PH_WAIT && tick_reg == 24'd0 && match_reg == 3'd0))
        else $error("SET sent without restarting the wait");
`endif

endmodule

### hdl/sush_queue.sv
`timescale 1ns / 1ps

module sush_queue #(
    parameter int DEPTH = sush_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sush_pkg::q_req_t    push,
    input  logic                pop,
    output sush_pkg::q_req_t    head,
    output logic                full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    sush_pkg::cmd_t slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg,  count_next;
    logic           do_push, do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push.cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> !full)
        else $error("work pushed into a full queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == CNT_FULL) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");
`endif

endmodule

### hdl/sush_back.sv
`timescale 1ns / 1ps

module sush_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  sush_pkg::q_req_t    head,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);

    logic       active_reg, active_next;
    logic [2:0] beat_reg,   beat_next;
    logic       valid_reg,  valid_next;
    logic [7:0] data_reg,   data_next;
    logic [1:0] kind_reg,   kind_next;
    logic       last_reg,   last_next;
    logic       advance;

    assign advance = !valid_reg || m_tready;

    always_comb begin
        active_next = active_reg;
        beat_next   = beat_reg;
        valid_next  = valid_reg;
        data_next   = data_reg;
        kind_next   = kind_reg;
        last_next   = last_reg;
        pop         = 1'b0;
        if (advance) begin
            valid_next = 1'b0;
            if (active_reg) begin
                // rest of a SET frame
                valid_next = 1'b1;
                kind_next  = sush_pkg::KIND_TX;
                data_next  = sush_pkg::set_byte(beat_reg);
                last_next  = (beat_reg == sush_pkg::FRAME_LAST);
                beat_next  = beat_reg + 3'd1;
                if (beat_reg == sush_pkg::FRAME_LAST) begin
                    active_next = 1'b0;
                end
            end else if (head.valid) begin
                pop        = 1'b1;
                valid_next = 1'b1;
                unique case (head.cmd)
                    sush_pkg::CMD_SET: begin
                        kind_next   = sush_pkg::KIND_TX;
                        data_next   = sush_pkg::set_byte(3'd0);
                        last_next   = 1'b0;
                        active_next = 1'b1;
                        beat_next   = 3'd1;
                    end
                    sush_pkg::CMD_OK: begin
                        kind_next = sush_pkg::KIND_OK;
                        data_next = '0;
                        last_next = 1'b1;
                    end
                    default: begin
                        kind_next = sush_pkg::KIND_FAIL;
                        data_next = '0;
                        last_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            beat_reg   <= '0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            beat_reg   <= beat_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

`ifndef NO_ASSERTIONS
    a_no_pop_midframe: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> !pop)
        else $error("new work taken in the middle of a SET frame");

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && kind_reg != sush_pkg::KIND_TX) |-> (last_reg && data_reg == 8'd0))
        else $error("status result not marked last");

    a_beat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (beat_reg != 3'd0 && beat_reg <= sush_pkg::FRAME_LAST))
        else $error("SET beat index out of range");
`endif

endmodule

### hdl/set_ua_link_handshake_sender_unit.sv
`timescale 1ns / 1ps

// Sender side of a SET/UA link set-up handshake. Requests arrive on the s_ stream
// (tuser: 0 start, 1 received byte in tdata, 2 timer tick); the front end updates
// the handshake state in the cycle a request is taken and queues the work it
// causes, so a request can be taken every clock while the command queue
// (QUEUE_DEPTH entries) has room, even while results wait on m_tready. The back
// end turns each queued command into results through one output register at one
// beat per clock while m_tready is high: a start or a retransmission yields the
// five SET bytes, success or failure a single status beat. Registers (cfg_index
// 0: timeout in ticks, 1: SET attempts) should be written while no results are
// pending.
module set_ua_link_handshake_sender_unit #(
    parameter int QUEUE_DEPTH = sush_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic [1:0]  s_tuser,    // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] tx_byte
    output logic [1:0]  m_tuser,    // [1:0] out_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data
);

    sush_pkg::q_req_t q_push;
    sush_pkg::q_req_t q_head;
    logic             q_full;
    logic             q_pop;
    logic             s_accept;

    assign s_tready  = !q_full;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    sush_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_accept  (s_accept),
        .req_type  (s_tuser),
        .rx_byte   (s_tdata),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_push    (q_push)
    );

    sush_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .pop     (q_pop),
        .head    (q_head),
        .full    (q_full)
    );

    sush_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
